// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== sv/ebe_pkg.sv =====
// Types and constants for the element-by-element LU triangle solve block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ebe_pkg;
  localparam logic [2:0] MODE_LOAD_COEF = 3'd0;
  localparam logic [2:0] MODE_LOAD_CONN = 3'd1;
  localparam logic [2:0] MODE_WRITE_VEC = 3'd2;
  localparam logic [2:0] MODE_APPLY     = 3'd3;
  localparam logic [2:0] MODE_READ_VEC  = 3'd4;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ELEMENT = 2'd1;
  localparam logic [1:0] ST_ADDRESS = 2'd2;
  localparam logic [1:0] ST_SLOT    = 2'd3;
  localparam int FRAC_BITS = 16;
  localparam int CFG_WIDTH = 13;
  localparam logic CFG_NUM_EQ = 1'b0;
  localparam logic CFG_NUM_EL = 1'b1;
  // datapath operations
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_RD_F    = 4'd1;  // read factor word
  localparam logic [3:0] OP_RD_C    = 4'd2;  // read corner
  localparam logic [3:0] OP_RD_V    = 4'd3;  // gather vector entry to z[sel]
  localparam logic [3:0] OP_MUL     = 4'd4;  // p = f * z[sel] (or z*f)
  localparam logic [3:0] OP_SUB     = 4'd5;  // z[sel] = z[sel] - p
  localparam logic [3:0] OP_MOVP    = 4'd6;  // z[sel] = p
  localparam logic [3:0] OP_WR_V    = 4'd7;  // scatter z[sel]
  localparam logic [3:0] OP_SINGLE  = 4'd8;  // store ops for the load and write modes
  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;   // z register / corner index
    logic [2:0] word;  // factor word index 0..7 (f1..f8)
  } ebe_cmd_t;
endpackage
`default_nettype wire

// ===== sv/ebe_datapath.sv =====
// Datapath: vector, factor and corner memories, z registers, multiplier, saturating subtract.
// Depends on ebe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ebe_datapath #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int VECTOR_DEPTH = 4096,
  parameter int DATA_WIDTH   = 32
) (
  input  wire logic                  clk,
  input  ebe_pkg::ebe_cmd_t          cmd,
  input  wire logic [2:0]            mode,
  input  wire logic [11:0]           element,
  input  wire logic [2:0]            slot,
  input  wire logic [11:0]           address,
  input  wire logic signed [31:0]    value,
  input  wire logic [11:0]           num_eq,
  output logic signed [31:0]         rd_value
);
  import ebe_pkg::*;
  localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int VW = $clog2(VECTOR_DEPTH);
  localparam int FW = EW + 3;
  localparam int CD = MAX_ELEMENTS * 3;
  localparam int CW = $clog2(CD);
  localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] vmem [VECTOR_DEPTH];
  logic signed [DATA_WIDTH-1:0] fmem [MAX_ELEMENTS*8];
  logic [11:0]                  cmem [CD];

  logic signed [DATA_WIDTH-1:0] z_r [3];
  logic [11:0]                  c_r [3];
  logic signed [DATA_WIDTH-1:0] f_r, v_r, p_r;
  logic [11:0]                  crd_r;
  logic                         vreal_r;

  function automatic logic signed [DATA_WIDTH-1:0] clamp32(input logic signed [31:0] x);
    logic signed [63:0] w;
    w = 64'(x);
    if (w > 64'(VMAX)) return VMAX;
    if (w < 64'(VMIN)) return VMIN;
    return DATA_WIDTH'(w);
  endfunction

  function automatic logic is_real(input logic [11:0] idx, input logic [11:0] ne);
    return (idx < ne) && (32'(idx) < VECTOR_DEPTH);
  endfunction

  logic [EW-1:0] el;
  logic [FW-1:0] faddr;
  logic [CW-1:0] caddr_w, caddr_r;
  logic [11:0]   vidx;
  assign el      = EW'(element);
  assign faddr   = {el, cmd.word};
  assign caddr_w = CW'(el * 3 + slot[1:0]);
  assign caddr_r = CW'(el * 3 + cmd.sel);
  assign vidx    = (cmd.op == OP_SINGLE || cmd.op == OP_RD_V && mode == MODE_READ_VEC)
                   ? address : c_r[cmd.sel];

  // product, floor shift, saturate
  logic signed [2*DATA_WIDTH-1:0] prod;
  logic signed [2*DATA_WIDTH-1:0] sh;
  logic signed [DATA_WIDTH-1:0]   pmul;
  assign prod = f_r * z_r[cmd.sel];
  always_comb begin
    sh = prod >>> FRAC_BITS;
    if (sh > (2*DATA_WIDTH)'(VMAX)) pmul = VMAX;
    else if (sh < (2*DATA_WIDTH)'(VMIN)) pmul = VMIN;
    else pmul = DATA_WIDTH'(sh);
  end

  logic signed [DATA_WIDTH:0]   diff;
  logic signed [DATA_WIDTH-1:0] dsat;
  always_comb begin
    diff = (DATA_WIDTH+1)'(z_r[cmd.sel]) - (DATA_WIDTH+1)'(p_r);
    if (diff > (DATA_WIDTH+1)'(VMAX)) dsat = VMAX;
    else if (diff < (DATA_WIDTH+1)'(VMIN)) dsat = VMIN;
    else dsat = DATA_WIDTH'(diff);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SINGLE: begin
        case (mode)
          MODE_LOAD_COEF: fmem[FW'({el, slot})] <= clamp32(value);
          MODE_LOAD_CONN: cmem[caddr_w] <= address;
          MODE_WRITE_VEC: if (is_real(address, num_eq)) vmem[VW'(address)] <= clamp32(value);
          default: ;
        endcase
      end
      OP_RD_F: f_r <= fmem[faddr];
      OP_RD_C: crd_r <= cmem[caddr_r];
      OP_RD_V: begin
        v_r     <= vmem[VW'(vidx)];
        vreal_r <= is_real(vidx, num_eq);
      end
      OP_MUL:  p_r <= pmul;
      OP_SUB:  z_r[cmd.sel] <= dsat;
      OP_MOVP: z_r[cmd.sel] <= p_r;
      OP_WR_V: if (is_real(c_r[cmd.sel], num_eq)) vmem[VW'(c_r[cmd.sel])] <= z_r[cmd.sel];
      default: ;
    endcase
    // latch steps that follow a corner read or a gather
    if (cmd.op == OP_NONE && cmd.word == 3'd1) c_r[cmd.sel] <= crd_r;
    if (cmd.op == OP_NONE && cmd.word == 3'd2) z_r[cmd.sel] <= vreal_r ? v_r : '0;
  end

  always_comb begin
    logic signed [DATA_WIDTH-1:0] rv;
    rv = vreal_r ? v_r : '0;
    if (64'(rv) > 64'sd2147483647) rd_value = 32'sh7FFFFFFF;
    else if (64'(rv) < -64'sd2147483648) rd_value = 32'sh80000000;
    else rd_value = 32'(rv);
  end
endmodule
`default_nettype wire

// ===== sv/ebe_ctrl.sv =====
// Controller: decodes a transfer, checks ranges, steps the datapath through apply.
// Depends on ebe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ebe_ctrl #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int VECTOR_DEPTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_mode,
  input  wire logic [11:0]        in_element,
  input  wire logic [2:0]         in_slot,
  input  wire logic [11:0]        in_address,
  input  wire logic [11:0]        num_eq,
  input  wire logic [12:0]        num_el,
  output ebe_pkg::ebe_cmd_t       cmd,
  output logic [2:0]              mode_q,
  output logic [11:0]             element_q,
  output logic [2:0]              slot_q,
  output logic [11:0]             address_q,
  input  wire logic signed [31:0] rd_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_read_value,
  output logic [1:0]              out_status
);
  import ebe_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic [1:0] st_r;
  logic       rd_r;

  // apply program: 3x(rd corner, latch), 3x(gather, latch), math, 3 scatters
  localparam int NSTEP = 33;
  function automatic ebe_cmd_t prog(input logic [5:0] s);
    ebe_cmd_t c;
    c = '{op: OP_NONE, sel: 2'd0, word: 3'd0};
    case (s)
      6'd0:  c = '{OP_RD_C, 2'd0, 3'd0};
      6'd1:  c = '{OP_NONE, 2'd0, 3'd1};
      6'd2:  c = '{OP_RD_C, 2'd1, 3'd0};
      6'd3:  c = '{OP_NONE, 2'd1, 3'd1};
      6'd4:  c = '{OP_RD_C, 2'd2, 3'd0};
      6'd5:  c = '{OP_NONE, 2'd2, 3'd1};
      6'd6:  c = '{OP_RD_V, 2'd0, 3'd0};
      6'd7:  c = '{OP_NONE, 2'd0, 3'd2};
      6'd8:  c = '{OP_RD_V, 2'd1, 3'd0};
      6'd9:  c = '{OP_NONE, 2'd1, 3'd2};
      6'd10: c = '{OP_RD_V, 2'd2, 3'd0};
      6'd11: c = '{OP_NONE, 2'd2, 3'd2};
      // z1 -= f3*z0
      6'd12: c = '{OP_RD_F, 2'd0, 3'd2};
      6'd13: c = '{OP_MUL,  2'd0, 3'd0};
      6'd14: c = '{OP_SUB,  2'd1, 3'd0};
      // z2 -= f6*z0 ; z2 -= f7*z1
      6'd15: c = '{OP_RD_F, 2'd0, 3'd5};
      6'd16: c = '{OP_MUL,  2'd0, 3'd0};
      6'd17: c = '{OP_SUB,  2'd2, 3'd0};
      6'd18: c = '{OP_RD_F, 2'd0, 3'd6};
      6'd19: c = '{OP_MUL,  2'd1, 3'd0};
      6'd20: c = '{OP_SUB,  2'd2, 3'd0};
      // z2 = z2*f8
      6'd21: c = '{OP_RD_F, 2'd0, 3'd7};
      6'd22: c = '{OP_MUL,  2'd2, 3'd0};
      6'd23: c = '{OP_MOVP, 2'd2, 3'd0};
      // z1 = (z1 - f5*z2)*f4
      6'd24: c = '{OP_RD_F, 2'd0, 3'd4};
      6'd25: c = '{OP_MUL,  2'd2, 3'd0};
      6'd26: c = '{OP_SUB,  2'd1, 3'd0};
      6'd27: c = '{OP_RD_F, 2'd0, 3'd3};
      6'd28: c = '{OP_MUL,  2'd1, 3'd0};
      6'd29: c = '{OP_MOVP, 2'd1, 3'd0};
      // z0 -= f1*z1 ; z0 -= f2*z2
      6'd30: c = '{OP_RD_F, 2'd0, 3'd0};
      6'd31: c = '{OP_MUL,  2'd1, 3'd0};
      6'd32: c = '{OP_SUB,  2'd0, 3'd0};
      6'd33: c = '{OP_RD_F, 2'd0, 3'd1};
      6'd34: c = '{OP_MUL,  2'd2, 3'd0};
      6'd35: c = '{OP_SUB,  2'd0, 3'd0};
      6'd36: c = '{OP_WR_V, 2'd0, 3'd0};
      6'd37: c = '{OP_WR_V, 2'd1, 3'd0};
      6'd38: c = '{OP_WR_V, 2'd2, 3'd0};
      default: c = '{op: OP_NONE, sel: 2'd0, word: 3'd0};
    endcase
    return c;
  endfunction
  localparam logic [5:0] LAST = 6'(NSTEP + 5);

  function automatic logic addr_bad(input logic [11:0] a, input logic [11:0] ne);
    return (a > ne) || ((a != ne) && (32'(a) >= VECTOR_DEPTH));
  endfunction

  logic       accept;
  logic [1:0] chk;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    chk = ST_OK;
    case (in_mode)
      MODE_LOAD_COEF: if (32'(in_element) >= MAX_ELEMENTS) chk = ST_ELEMENT;
      MODE_LOAD_CONN: begin
        if (32'(in_element) >= MAX_ELEMENTS) chk = ST_ELEMENT;
        else if (in_slot > 3'd2) chk = ST_SLOT;
        else if (addr_bad(in_address, num_eq)) chk = ST_ADDRESS;
      end
      MODE_WRITE_VEC, MODE_READ_VEC: if (addr_bad(in_address, num_eq)) chk = ST_ADDRESS;
      MODE_APPLY: if (13'(in_element) >= num_el || 32'(in_element) >= MAX_ELEMENTS)
        chk = ST_ELEMENT;
      default: chk = ST_OK;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd = '{op: OP_NONE, sel: 2'd0, word: 3'd0};
    case (state_r)
      S_IDLE: if (accept) begin
        state_nxt = S_RUN;
        step_nxt  = '0;
      end
      S_RUN: begin
        if (st_r != ST_OK) state_nxt = S_OUT;
        else if (mode_q == MODE_APPLY) begin
          cmd = prog(step_r);
          step_nxt = step_r + 6'd1;
          if (step_r == LAST) state_nxt = S_OUT;
        end else if (mode_q == MODE_READ_VEC) begin
          if (step_r == 6'd0) cmd = '{OP_RD_V, 2'd0, 3'd0};
          step_nxt = step_r + 6'd1;
          if (step_r == 6'd1) state_nxt = S_OUT;
        end else begin
          cmd = '{OP_SINGLE, 2'd0, 3'd0};
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    if (accept) begin
      mode_q    <= in_mode;
      element_q <= in_element;
      slot_q    <= in_slot;
      address_q <= in_address;
      st_r      <= chk;
      rd_r      <= (in_mode == MODE_READ_VEC) && (chk == ST_OK);
    end
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_status     = st_r;
  assign out_read_value = rd_r ? rd_value : 32'sd0;
endmodule
`default_nettype wire

// ===== sv/ebe_lu_triangle_solve.sv =====
// Use: one input channel (in_valid/in_stall) carries mode, element, slot,
// address and value; each transfer gives exactly one result on the output
// channel (out_valid/out_stall) with read_value and status.
// Configuration writes through cfg_we/cfg_index/cfg_data, only while idle.
// In an apply, corner reads, three gathers, eight multiply steps and three
// scatters go through the single-port memories in turn.
// One item is in work at a time; in_stall is high from transfer until the
// result has been taken, so the next transfer can come in the cycle after it.
// Results hold while out_stall is high.
// Synchronous active-low reset returns the controller to idle and sets
// num_equations to 4095 and num_elements to 0; memory contents are kept
// and are undefined until written. Out-of-range requests answer a status
// code with no effect on stored data.
// Depends on ebe_pkg, ebe_ctrl and ebe_datapath.
`timescale 1ns / 1ps
`default_nettype none
module ebe_lu_triangle_solve #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int VECTOR_DEPTH = 4096,
  parameter int DATA_WIDTH   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_mode,
  input  wire logic [11:0]         in_element,
  input  wire logic [2:0]          in_slot,
  input  wire logic [11:0]         in_address,
  input  wire logic signed [31:0]  in_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       out_read_value,
  output logic [1:0]               out_status,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [12:0]         cfg_data
);
  import ebe_pkg::*;
  logic [11:0] num_eq_r;
  logic [12:0] num_el_r;
  ebe_cmd_t    cmd;
  logic [2:0]  mode_q, slot_q;
  logic [11:0] element_q, address_q;
  logic signed [31:0] value_r, rd_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_eq_r <= 12'd4095;
      num_el_r <= 13'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_EQ) num_eq_r <= cfg_data[11:0];
      else num_el_r <= cfg_data;
    end
    if (in_valid && !in_stall) value_r <= in_value;
  end

  ebe_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS), .VECTOR_DEPTH(VECTOR_DEPTH)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_element, .in_slot, .in_address,
    .num_eq(num_eq_r), .num_el(num_el_r), .cmd, .mode_q, .element_q, .slot_q,
    .address_q, .rd_value, .out_valid, .out_stall, .out_read_value, .out_status
  );

  ebe_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS), .VECTOR_DEPTH(VECTOR_DEPTH),
                 .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .cmd, .mode(mode_q), .element(element_q), .slot(slot_q), .address(address_q),
    .value(value_r), .num_eq(num_eq_r), .rd_value
  );
endmodule
`default_nettype wire

// ===== sv/ebe_checker.sv =====
// Port-level checker for ebe_lu_triangle_solve, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ebe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_value,
  input wire logic [1:0]  out_status
);
  `CHK_IMPL(a_one_at_a_time, clk, rst_n, out_valid, in_stall)
  `CHK_NEXT(a_accept_blocks, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_NEXT(a_result_holds, clk, rst_n, out_valid && out_stall,
            out_valid && $stable(out_read_value) && $stable(out_status))
  `CHK_IMPL(a_no_read_on_error, clk, rst_n, out_valid && out_status != 2'd0,
            out_read_value == 32'd0)
endmodule
bind ebe_lu_triangle_solve ebe_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_read_value, .out_status
);
`default_nettype wire

// ===== verif/ebe_lu_triangle_solve_test.sv =====
// Self-checking testbench for ebe_lu_triangle_solve: a directed table, then random
// transfers over several register settings, checked against given results or an in-bench predictor.
// Depends on ebe_pkg and the ebe_lu_triangle_solve RTL.
`timescale 1ns / 1ps
module ebe_lu_triangle_solve_test;
  import ebe_pkg::*;

  localparam logic [2:0] MODE_SPARE = 3'd5;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [2:0] mode;
    logic [11:0] element;
    logic [2:0] slot;
    logic [11:0] address;
    logic signed [31:0] value;
  } req_t;

  typedef struct {
    logic signed [31:0] rd;
    logic [1:0] st;
  } res_t;

  typedef struct {
    bit is_cfg;
    bit typed;
    req_t rq;
    res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic [11:0] in_element = '0;
  logic [2:0] in_slot = '0;
  logic [11:0] in_address = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_read_value;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  ebe_lu_triangle_solve dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [12:0] num_eq, num_el;
  logic signed [31:0] vec_mem[4096];
  logic signed [31:0] factor_mem[32768];
  logic [11:0] corner_mem[12288];
  bit vec_set[4096];
  bit factor_set[32768];
  bit corner_set[12288];

  res_t result_q[$];
  row_t plan[$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  logic [11:0] pool[8] = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd4095};

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
    return sat32(longint'(a) - longint'(b));
  endfunction

  function automatic bit is_real(logic [11:0] idx);
    return idx < num_eq;
  endfunction

  function automatic bit safe(req_t r);
    int e;
    e = r.element;
    if (r.mode == MODE_READ_VEC)
      return !(r.address <= num_eq && is_real(r.address) && !vec_set[r.address]);
    if (r.mode != MODE_APPLY || e >= num_el) return 1'b1;
    for (int k = 0; k < 8; k++) if (!factor_set[e*8+k]) return 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!corner_set[e*3+k]) return 1'b0;
      if (is_real(corner_mem[e*3+k]) && !vec_set[corner_mem[e*3+k]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic solve_element(int e);
    logic [11:0] c0, c1, c2;
    logic signed [31:0] z0, z1, z2;
    c0 = corner_mem[e*3];
    c1 = corner_mem[e*3+1];
    c2 = corner_mem[e*3+2];
    z0 = is_real(c0) ? vec_mem[c0] : 0;
    z1 = is_real(c1) ? vec_mem[c1] : 0;
    z2 = is_real(c2) ? vec_mem[c2] : 0;
    z1 = qsub(z1, qmul(factor_mem[e*8+2], z0));
    z2 = qsub(qsub(z2, qmul(factor_mem[e*8+5], z0)), qmul(factor_mem[e*8+6], z1));
    z2 = qmul(z2, factor_mem[e*8+7]);
    z1 = qmul(qsub(z1, qmul(factor_mem[e*8+4], z2)), factor_mem[e*8+3]);
    z0 = qsub(qsub(z0, qmul(factor_mem[e*8], z1)), qmul(factor_mem[e*8+1], z2));
    if (is_real(c0)) vec_mem[c0] = z0;
    if (is_real(c1)) vec_mem[c1] = z1;
    if (is_real(c2)) vec_mem[c2] = z2;
  endtask

  task automatic predict(input req_t r, output res_t o);
    int e;
    e = r.element;
    o.rd = 0;
    o.st = ST_OK;
    case (r.mode)
      MODE_LOAD_COEF: begin
        factor_mem[e*8+r.slot] = r.value;
        factor_set[e*8+r.slot] = 1'b1;
      end
      MODE_LOAD_CONN: begin
        if (r.slot > 3'd2) o.st = ST_SLOT;
        else if (r.address > num_eq) o.st = ST_ADDRESS;
        else begin
          corner_mem[e*3+r.slot] = r.address;
          corner_set[e*3+r.slot] = 1'b1;
        end
      end
      MODE_WRITE_VEC: begin
        if (r.address > num_eq) o.st = ST_ADDRESS;
        else if (is_real(r.address)) begin
          vec_mem[r.address] = r.value;
          vec_set[r.address] = 1'b1;
        end
      end
      MODE_APPLY: begin
        if (e >= num_el) o.st = ST_ELEMENT;
        else solve_element(e);
      end
      MODE_READ_VEC: begin
        if (r.address > num_eq) o.st = ST_ADDRESS;
        else if (is_real(r.address)) o.rd = vec_mem[r.address];
      end
      default: ;
    endcase
  endtask

  function automatic logic [11:0] pick_addr();
    int lim;
    lim = (num_eq < 63) ? num_eq : 63;
    case ($urandom_range(0, 4))
      0: return 12'($urandom);
      1: return num_eq[11:0];
      2: return 12'(num_eq - $urandom_range(0, lim));
      default: return 12'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sh00010000;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    int sel;
    do begin
      sel = $urandom_range(0, 99);
      r.element = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 7)] : 12'($urandom);
      r.slot = 3'($urandom);
      r.address = pick_addr();
      r.value = pick_value();
      if (sel < 16) r.mode = MODE_LOAD_COEF;
      else if (sel < 28) begin
        r.mode = MODE_LOAD_CONN;
        if ($urandom_range(0, 5) != 0) r.slot = 3'($urandom_range(0, 2));
      end else if (sel < 48) r.mode = MODE_WRITE_VEC;
      else if (sel < 73) r.mode = MODE_APPLY;
      else if (sel < 96) r.mode = MODE_READ_VEC;
      else r.mode = 3'($urandom_range(MODE_SPARE, 7));
    end while (!safe(r));
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 13'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUM_EQ) num_eq = 13'(val[11:0]);
    else num_el = 13'(val);
    @(posedge clk);
  endtask

  task automatic send(req_t r, bit typed, res_t want);
    int gap;
    res_t p;
    gap = calm ? 0 : $urandom_range(0, 7);
    predict(r, p);
    result_q.push_back(typed ? want : p);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_element <= r.element;
    in_slot <= r.slot;
    in_address <= r.address;
    in_value <= r.value;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic row_t op(logic [2:0] m, int e, int s, int a, logic [31:0] v);
    row_t w;
    w.is_cfg = 1'b0;
    w.typed = 1'b0;
    w.rq = '{m, 12'(e), 3'(s), 12'(a), v};
    w.want = '{0, ST_OK};
    return w;
  endfunction

  function automatic row_t opx(logic [2:0] m, int e, int s, int a, logic [31:0] v,
                               logic [31:0] rd, logic [1:0] st);
    row_t w;
    w = op(m, e, s, a, v);
    w.typed = 1'b1;
    w.want = '{rd, st};
    return w;
  endfunction

  function automatic row_t cf(logic idx, int val);
    row_t w;
    w = op(MODE_SPARE, 0, 0, 0, 0);
    w.is_cfg = 1'b1;
    w.rq.element = idx;
    w.rq.address = 12'(val);
    w.rq.value = val;
    return w;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("ebe_lu_triangle_solve_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) report("unexpected transfer", out_read_value, 0);
        else begin
          res_t w;
          w = result_q.pop_front();
          if (out_read_value !== w.rd) report("read_value", out_read_value, w.rd);
          if (out_status !== w.st) report("status", 32'(out_status), 32'(w.st));
        end
        stall_left = calm ? 0 : $urandom_range(0, 7);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  int eqs[6] = '{4095, 1, 37, 600, 4095, 2};
  int els[6] = '{4096, 4096, 0, 13, 5, 4096};

  initial begin
    num_eq = 13'd4095;
    num_el = 13'd0;
    plan.push_back(opx(MODE_READ_VEC, 0, 0, 4095, 0, 0, ST_OK));
    plan.push_back(opx(MODE_WRITE_VEC, 0, 0, 4095, 32'h7FFFFFFF, 0, ST_OK));
    plan.push_back(opx(MODE_APPLY, 0, 0, 0, 0, 0, ST_ELEMENT));
    plan.push_back(opx(MODE_LOAD_CONN, 0, 3, 0, 0, 0, ST_SLOT));
    plan.push_back(opx(3'd7, 4095, 7, 4095, 32'hFFFFFFFF, 0, ST_OK));
    plan.push_back(cf(CFG_NUM_EQ, 8));
    plan.push_back(cf(CFG_NUM_EL, 4096));
    plan.push_back(opx(MODE_WRITE_VEC, 0, 0, 9, 1, 0, ST_ADDRESS));
    plan.push_back(opx(MODE_READ_VEC, 0, 0, 4095, 0, 0, ST_ADDRESS));
    plan.push_back(opx(MODE_LOAD_CONN, 4095, 2, 9, 0, 0, ST_ADDRESS));
    plan.push_back(op(MODE_WRITE_VEC, 0, 0, 0, 32'h7FFFFFFF));
    plan.push_back(op(MODE_WRITE_VEC, 0, 0, 1, 32'h80000000));
    plan.push_back(opx(MODE_READ_VEC, 0, 0, 1, 0, 32'h80000000, ST_OK));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 0, 0, 32'h80000000));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 1, 0, 32'h7FFFFFFF));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 2, 0, 32'h00010000));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 3, 0, 32'hFFFF0000));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 4, 0, 32'h00008000));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 5, 0, 32'h7FFFFFFF));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 6, 0, 32'h00000001));
    plan.push_back(op(MODE_LOAD_COEF, 4095, 7, 0, 32'h80000000));
    // corner 1 on the dummy slot, corner 2 repeats corner 0
    plan.push_back(op(MODE_LOAD_CONN, 4095, 0, 0, 0));
    plan.push_back(op(MODE_LOAD_CONN, 4095, 1, 8, 0));
    plan.push_back(op(MODE_LOAD_CONN, 4095, 2, 0, 0));
    plan.push_back(op(MODE_APPLY, 4095, 0, 0, 0));
    plan.push_back(op(MODE_READ_VEC, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].rq.element[0], plan[i].rq.value);
      end else send(plan[i].rq, plan[i].typed, plan[i].want);
    end
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(CFG_NUM_EQ, eqs[p]);
      write_reg(CFG_NUM_EL, els[p]);
      for (int n = 0; n < 150; n++) begin
        res_t none;
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        none = '{0, ST_OK};
        send(random_req(), 1'b0, none);
      end
    end
    wait_idle();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("ebe_lu_triangle_solve_test passed");
    else $display("ebe_lu_triangle_solve_test failed");
    $finish;
  end
endmodule
